>>> design/rsti_pkg.sv
`default_nettype none

package rsti_pkg;

	localparam int AccW   = 64;
	localparam int RadixW = 6;
	localparam int DigitW = 6;
	localparam int CharW  = 8;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_RADIX = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_RADIX  = 1'b0,
		CFG_SIGNED = 1'b1
	} cfg_index_t;

	localparam logic [CharW-1:0]  DIGIT_LOW_MASK = 8'h0f;
	localparam logic [CharW-1:0]  LETTER_MASK    = 8'h1f;
	localparam logic [CharW-1:0]  CASE_FOLD      = 8'h20;
	localparam logic [RadixW-1:0] MAX_RADIX      = 6'd36;
	localparam logic [RadixW-1:0] RADIX_RESET    = 6'd10;
	localparam logic [RadixW-1:0] RADIX_BIN      = 6'd2;
	localparam logic [RadixW-1:0] RADIX_OCT      = 6'd8;
	localparam logic [RadixW-1:0] RADIX_DEC      = 6'd10;
	localparam logic [RadixW-1:0] RADIX_HEX      = 6'd16;
	localparam logic [RadixW-1:0] RADIX_PENDING  = 6'd0;

	localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_UC_A  = 8'h41;
	localparam logic [CharW-1:0] CH_UC_Z  = 8'h5a;
	localparam logic [CharW-1:0] CH_LC_A  = 8'h61;
	localparam logic [CharW-1:0] CH_LC_Z  = 8'h7a;
	localparam logic [CharW-1:0] CH_LC_B  = 8'h62;
	localparam logic [CharW-1:0] CH_LC_D  = 8'h64;
	localparam logic [CharW-1:0] CH_LC_O  = 8'h6f;
	localparam logic [CharW-1:0] CH_LC_X  = 8'h78;

	typedef struct packed {
		logic              ok;
		logic [DigitW-1:0] val;
	} digit_t;

	typedef struct packed {
		logic [AccW-1:0] mag;
		logic            neg;
		status_t         status;
	} result_t;

	function automatic digit_t decode_digit(input logic [CharW-1:0] c);
		digit_t     d;
		logic [CharW-1:0] t;
		d.ok  = 1'b0;
		d.val = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t     = c & DIGIT_LOW_MASK;
			d.ok  = 1'b1;
			d.val = t[DigitW-1:0];
		end else if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
			t     = (c & LETTER_MASK) + 8'd9;
			d.ok  = 1'b1;
			d.val = t[DigitW-1:0];
		end
		return d;
	endfunction

	function automatic logic radix_ok(input logic [RadixW-1:0] r);
		return (r >= RADIX_BIN) && (r <= MAX_RADIX);
	endfunction

endpackage

`default_nettype wire

>>> design/radix_string_to_integer_top.sv
// Streaming string-to-integer converter. Characters of one number string enter one per
// transaction on the slave side, with tlast on the final character; each final character
// yields one result transaction carrying the 64-bit value and a 2-bit status (0 ok, 1 empty,
// 2 bad radix, 3 overflow), other characters yield nothing. Throughput is one character per
// cycle: the character sits in an input register, the accumulator update (a 64 by 6 bit
// multiply and digit add) is done from there and registered in the core, and the result of a
// final character lands in an output register that drives m_tvalid. Only a final character
// ever waits, and only while the previous result is still held by a stalled
// receiver. The radix register (index 0, 2..36, 0 deduces from a 0b/0o/0d/0x prefix or a
// leading zero) and the signed_mode register (index 1) may be written only while no string
// is in progress.
`default_nettype none

module radix_string_to_integer_top
	import rsti_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] character
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // [63:0] value
	output logic      [1:0]  m_tuser,   // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data
);

	logic [RadixW-1:0] radix_q;
	logic              signed_q;

	logic              valid_s1;
	logic [CharW-1:0]  char_s1;
	logic              last_s1;
	logic              advance;
	logic              fire;

	result_t           core_res;
	result_t           res_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			signed_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_RADIX:  radix_q  <= cfg_data;
				CFG_SIGNED: signed_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// non-final characters never wait on the output register
	assign advance  = !last_s1 || !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	rsti_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.character   (char_s1),
		.last_char   (last_s1),
		.radix       (radix_q),
		.signed_mode (signed_q),
		.res         (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q.neg ? (64'd0 - res_q.mag) : res_q.mag;
	assign m_tuser  = res_q.status;

endmodule

`default_nettype wire

>>> design/rsti_mac.sv
`default_nettype none

module rsti_mac
	import rsti_pkg::*;
(
	input  wire logic [AccW-1:0]   acc,
	input  wire logic [RadixW-1:0] radix,
	input  wire logic [DigitW-1:0] digit,
	output logic      [AccW-1:0]   sum,
	output logic                   ovf
);

	logic [AccW+RadixW-1:0] prod;
	logic [AccW:0]          wide_sum;

	always_comb begin
		prod     = {{RadixW{1'b0}}, acc} * {{AccW{1'b0}}, radix};
		wide_sum = {1'b0, prod[AccW-1:0]} + {{(AccW+1-DigitW){1'b0}}, digit};
		sum      = wide_sum[AccW-1:0];
		// product beyond 64 bits or carry out of the digit add
		ovf      = (|prod[AccW+RadixW-1:AccW]) | wide_sum[AccW];
	end

endmodule

`default_nettype wire

>>> design/rsti_core.sv
`default_nettype none

module rsti_core
	import rsti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [CharW-1:0]  character,
	input  wire logic              last_char,
	input  wire logic [RadixW-1:0] radix,
	input  wire logic              signed_mode,
	output result_t                res
);

	logic [AccW-1:0]   acc_q, acc_d;
	logic [1:0]        pos_q, pos_d;
	logic [RadixW-1:0] ar_q, ar_d;
	logic              neg_q, neg_d;
	logic              stop_q, stop_d;
	logic              ovf_q, ovf_d;

	logic [CharW-1:0]  lower;
	logic              sign_take;
	logic              pos0;
	logic              pend;
	logic [RadixW-1:0] ar_first;
	logic [RadixW-1:0] pfx_radix;
	logic              pfx_hit;
	logic              skip;
	logic [RadixW-1:0] ar_eff;
	logic              take_en;
	digit_t            dig;
	logic [AccW-1:0]   mac_sum;
	logic              mac_ovf;

	rsti_mac u_mac (
		.acc   (acc_q),
		.radix (ar_eff),
		.digit (dig.val),
		.sum   (mac_sum),
		.ovf   (mac_ovf)
	);

	always_comb begin
		lower     = character | CASE_FOLD;
		dig       = decode_digit(character);
		pos0      = (pos_q == 2'd0);
		pend      = (pos_q == 2'd1) && (ar_q == RADIX_PENDING);
		sign_take = pos0 && !neg_q && signed_mode && (character == CH_MINUS);

		if (radix == RADIX_PENDING) begin
			ar_first = (character == CH_ZERO && !last_char) ? RADIX_PENDING : RADIX_DEC;
		end else begin
			ar_first = radix;
		end

		pfx_hit   = 1'b1;
		pfx_radix = RADIX_OCT;
		unique case (lower)
			CH_LC_B: pfx_radix = RADIX_BIN;
			CH_LC_O: pfx_radix = RADIX_OCT;
			CH_LC_D: pfx_radix = RADIX_DEC;
			CH_LC_X: pfx_radix = RADIX_HEX;
			default: pfx_hit = 1'b0;
		endcase

		// a prefix matching the given radix after a leading zero is skipped
		skip = (pos_q == 2'd1) && (ar_q != RADIX_PENDING) && (acc_q == '0) && !stop_q
			&& !ovf_q && pfx_hit && (pfx_radix == ar_q);

		if (pos0) begin
			ar_eff = ar_first;
		end else if (pend) begin
			ar_eff = pfx_radix;
		end else begin
			ar_eff = ar_q;
		end

		take_en = !sign_take && !(pend && pfx_hit) && !skip && !(pos0 && ar_first == RADIX_PENDING)
			&& !stop_q && !ovf_q && radix_ok(ar_eff);

		acc_d  = acc_q;
		stop_d = stop_q;
		ovf_d  = ovf_q;
		if (take_en) begin
			if (!dig.ok || dig.val >= ar_eff) begin
				stop_d = 1'b1;
			end else if (mac_ovf) begin
				ovf_d  = 1'b1;
				stop_d = 1'b1;
			end else begin
				acc_d = mac_sum;
			end
		end

		ar_d  = sign_take ? ar_q : ar_eff;
		neg_d = neg_q | sign_take;
		if (sign_take || pos_q == 2'd2) begin
			pos_d = pos_q;
		end else begin
			pos_d = pos_q + 2'd1;
		end

		res.mag    = '0;
		res.neg    = 1'b0;
		res.status = ST_OK;
		priority if (sign_take) begin
			res.status = ST_EMPTY;
		end else if (!radix_ok(ar_d)) begin
			res.status = ST_BAD_RADIX;
		end else if (ovf_d) begin
			res.status = ST_OVERFLOW;
		end else begin
			res.mag = acc_d;
			res.neg = neg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			ar_q   <= '0;
			neg_q  <= 1'b0;
			stop_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (fire) begin
			if (last_char) begin
				acc_q  <= '0;
				pos_q  <= '0;
				ar_q   <= '0;
				neg_q  <= 1'b0;
				stop_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				acc_q  <= acc_d;
				pos_q  <= pos_d;
				ar_q   <= ar_d;
				neg_q  <= neg_d;
				stop_q <= stop_d;
				ovf_q  <= ovf_d;
			end
		end
	end

endmodule

`default_nettype wire
